// ===== rtl/ata_pkg.sv =====
`timescale 1ns / 1ps
package ata_pkg;

  // sector geometry and settle delay
  localparam int unsigned SECTOR_WORDS = 256;
  localparam int unsigned SETTLE_READS = 4;
  localparam int unsigned WIDX_W       = $clog2(SECTOR_WORDS + 1);
  localparam int unsigned SETTLE_W     = $clog2(SETTLE_READS + 1);

  // results one item may cause
  localparam int unsigned MAX_RES = 6;
  localparam int unsigned RCNT_W  = $clog2(MAX_RES + 1);

  // command queue between front and back
  localparam int unsigned FIFO_DEPTH = 2;

  // stream widths
  localparam int unsigned S_TDATA_W = 72;
  localparam int unsigned S_TUSER_W = 3;
  localparam int unsigned M_TDATA_W = 40;
  localparam int unsigned M_TUSER_W = 2;

  // output tdata bit positions
  localparam int unsigned MD_PORT_LSB = 0;
  localparam int unsigned MD_WR_BIT   = 3;
  localparam int unsigned MD_WORD_BIT = 4;
  localparam int unsigned MD_BD_LSB   = 5;
  localparam int unsigned MD_HD_LSB   = 21;
  localparam int unsigned MD_ST_LSB   = 37;

  localparam logic [31:0] SPIN_RESET = 32'd4000000;

  // input actions
  typedef enum logic [2:0] {
    ACT_READ  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_PROBE = 3'd2,
    ACT_REPLY = 3'd3,
    ACT_WWORD = 3'd4
  } act_e;

  // result kinds
  localparam logic [1:0] KIND_BUS  = 2'd0;
  localparam logic [1:0] KIND_HOST = 2'd1;
  localparam logic [1:0] KIND_REQ  = 2'd2;
  localparam logic [1:0] KIND_DONE = 2'd3;

  // completion codes
  localparam logic [1:0] DONE_OK      = 2'd0;
  localparam logic [1:0] DONE_ERR     = 2'd1;
  localparam logic [1:0] DONE_TIMEOUT = 2'd2;

  // operations
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PROBE = 2'd2;

  // task file offsets
  localparam logic [2:0] REG_DATA   = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd2;
  localparam logic [2:0] REG_LBA0   = 3'd3;
  localparam logic [2:0] REG_LBA1   = 3'd4;
  localparam logic [2:0] REG_LBA2   = 3'd5;
  localparam logic [2:0] REG_DEVICE = 3'd6;
  localparam logic [2:0] REG_STATUS = 3'd7;

  // command and device bytes
  localparam logic [7:0] DEV_SEL   = 8'hE0;
  localparam logic [7:0] CMD_READ  = 8'h20;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_FLUSH = 8'hE7;

  // status bits
  localparam logic [7:0] ST_BSY = 8'h80;
  localparam logic [7:0] ST_DF  = 8'h20;
  localparam logic [7:0] ST_DRQ = 8'h08;
  localparam logic [7:0] ST_ERR = 8'h01;

  typedef struct packed {
    act_e        act;
    logic [27:0] lba;
    logic [7:0]  count;
    logic [15:0] reply;
    logic [15:0] wword;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  port;
    logic        bus_write;
    logic        word_access;
    logic [15:0] bus_data;
    logic [15:0] host_data;
    logic [1:0]  done_status;
    logic        last;
  } res_t;

  function automatic res_t bus_res(logic [2:0] port, logic wr, logic word, logic [15:0] bd);
    res_t r;
    r             = '0;
    r.kind        = KIND_BUS;
    r.port        = port;
    r.bus_write   = wr;
    r.word_access = word;
    r.bus_data    = bd;
    return r;
  endfunction

  function automatic res_t stat_rd();
    return bus_res(REG_STATUS, 1'b0, 1'b0, 16'h0000);
  endfunction

  function automatic res_t byte_wr(logic [2:0] port, logic [7:0] v);
    return bus_res(port, 1'b1, 1'b0, {8'h00, v});
  endfunction

  function automatic res_t done_res(logic [1:0] st);
    res_t r;
    r             = '0;
    r.kind        = KIND_DONE;
    r.done_status = st;
    return r;
  endfunction

  function automatic res_t host_res(logic [15:0] d);
    res_t r;
    r           = '0;
    r.kind      = KIND_HOST;
    r.host_data = d;
    return r;
  endfunction

  function automatic res_t req_res();
    res_t r;
    r      = '0;
    r.kind = KIND_REQ;
    return r;
  endfunction

endpackage

// ===== rtl/ata_front.sv =====
`timescale 1ns / 1ps
module ata_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [ata_pkg::S_TDATA_W-1:0] s_data_i,
  input  logic [ata_pkg::S_TUSER_W-1:0] s_user_i,
  output logic                          push_o,
  output ata_pkg::item_t                item_o,
  input  logic                          full_i
);
  import ata_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q, item_d;
  logic  known;
  logic  take;

  // decode the action, unknown codes are dropped here
  always_comb begin
    known       = 1'b1;
    item_d      = item_q;
    item_d.act  = ACT_READ;
    unique case (s_user_i)
      ACT_READ:  item_d.act = ACT_READ;
      ACT_WRITE: item_d.act = ACT_WRITE;
      ACT_PROBE: item_d.act = ACT_PROBE;
      ACT_REPLY: item_d.act = ACT_REPLY;
      ACT_WWORD: item_d.act = ACT_WWORD;
      default:   known = 1'b0;
    endcase
    item_d.lba   = s_data_i[27:0];
    item_d.count = s_data_i[35:28];
    item_d.reply = s_data_i[51:36];
    item_d.wword = s_data_i[67:52];
  end

  assign s_ready_o = !valid_q || !full_i;
  assign take      = s_valid_i && s_ready_o;
  assign push_o    = valid_q && !full_i;
  assign item_o    = item_q;

  always_comb begin
    valid_d = valid_q;
    if (push_o) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d = known;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

// ===== rtl/ata_fifo.sv =====
`timescale 1ns / 1ps
module ata_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ata_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output ata_pkg::item_t item_o
);
  import ata_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  item_t            mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  function automatic logic [PTR_W-1:0] nxt(logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = push_i ? nxt(wptr_q) : wptr_q;
    rptr_d = pop_i ? nxt(rptr_q) : rptr_q;
    cnt_d  = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

endmodule

// ===== rtl/ata_back.sv =====
`timescale 1ns / 1ps
module ata_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [31:0]    cfg_data_i,
  input  logic           valid_i,
  input  ata_pkg::item_t item_i,
  output logic           pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output ata_pkg::res_t  res_o
);
  import ata_pkg::*;

  typedef enum logic [11:0] {
    PH_IDLE          = 12'b0000_0000_0001,
    PH_BSY_ISSUE     = 12'b0000_0000_0010,
    PH_SETTLE_SELECT = 12'b0000_0000_0100,
    PH_PROBE_STATUS  = 12'b0000_0000_1000,
    PH_BSY_SECTOR    = 12'b0000_0001_0000,
    PH_DRQ           = 12'b0000_0010_0000,
    PH_READ_DATA     = 12'b0000_0100_0000,
    PH_WRITE_WORD    = 12'b0000_1000_0000,
    PH_SETTLE_SECTOR = 12'b0001_0000_0000,
    PH_BSY_PREFLUSH  = 12'b0010_0000_0000,
    PH_BSY_POSTFLUSH = 12'b0100_0000_0000,
    PH_FINAL_STATUS  = 12'b1000_0000_0000
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [1:0]          op_q, op_d;
  logic [27:0]         addr_q, addr_d;
  logic [7:0]          sect_q, sect_d;
  logic [WIDX_W-1:0]   widx_q, widx_d;
  logic [31:0]         poll_q, poll_d;
  logic [SETTLE_W-1:0] settle_q, settle_d;
  logic [31:0]         spin_q;

  res_t                buf_q [MAX_RES];
  res_t                buf_d [MAX_RES];
  logic [RCNT_W-1:0]   cnt_q, cnt_d;

  res_t                rl [MAX_RES];
  logic [RCNT_W-1:0]   n;
  logic                do_poll;

  logic [7:0]          st;
  logic [31:0]         limit;
  logic                poll_out;
  logic [WIDX_W-1:0]   widx_inc;
  logic [7:0]          sect_dec;
  logic                can_load;
  logic                m_hs;

  assign st       = item_i.reply[7:0];
  assign limit    = (spin_q == '0) ? 32'd1 : spin_q;
  assign poll_out = (poll_q >= limit);
  assign widx_inc = widx_q + WIDX_W'(1);
  assign sect_dec = sect_q - 8'd1;

  assign m_valid_o = (cnt_q != '0);
  assign res_o     = buf_q[0];
  assign m_hs      = m_valid_o && m_ready_i;
  assign can_load  = (cnt_q == '0) || ((cnt_q == RCNT_W'(1)) && m_ready_i);
  assign pop_o     = valid_i && can_load;

  // sequencer step: builds the result list of one item and the next state
  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    addr_d   = addr_q;
    sect_d   = sect_q;
    widx_d   = widx_q;
    poll_d   = poll_q;
    settle_d = settle_q;
    n        = '0;
    do_poll  = 1'b0;
    for (int i = 0; i < MAX_RES; i++) begin
      rl[i] = '0;
    end
    if (pop_o) begin
      if (phase_q == PH_IDLE) begin
        if (item_i.act == ACT_READ || item_i.act == ACT_WRITE) begin
          if (item_i.count == '0) begin
            rl[n] = done_res(DONE_OK);
            n     = n + RCNT_W'(1);
          end else begin
            op_d    = (item_i.act == ACT_WRITE) ? OP_WRITE : OP_READ;
            addr_d  = item_i.lba;
            sect_d  = item_i.count;
            phase_d = PH_BSY_ISSUE;
            poll_d  = 32'd1;
            rl[n]   = stat_rd();
            n       = n + RCNT_W'(1);
          end
        end else if (item_i.act == ACT_PROBE) begin
          op_d    = OP_PROBE;
          phase_d = PH_BSY_ISSUE;
          poll_d  = 32'd1;
          rl[n]   = stat_rd();
          n       = n + RCNT_W'(1);
        end
      end else if (phase_q == PH_WRITE_WORD) begin
        if (item_i.act == ACT_WWORD) begin
          rl[n] = bus_res(REG_DATA, 1'b1, 1'b1, item_i.wword);
          n     = n + RCNT_W'(1);
          if (widx_inc != WIDX_W'(SECTOR_WORDS)) begin
            widx_d = widx_inc;
            rl[n]  = req_res();
            n      = n + RCNT_W'(1);
          end else begin
            widx_d   = '0;
            sect_d   = sect_dec;
            settle_d = SETTLE_W'(1);
            phase_d  = PH_SETTLE_SECTOR;
            rl[n]    = stat_rd();
            n        = n + RCNT_W'(1);
          end
        end
      end else if (item_i.act == ACT_REPLY) begin
        unique case (phase_q)
          PH_BSY_ISSUE: begin
            if ((st & ST_BSY) != '0) begin
              do_poll = 1'b1;
            end else begin
              rl[n]    = byte_wr(REG_DEVICE, (op_q == OP_PROBE) ? DEV_SEL
                                             : (DEV_SEL | {4'h0, addr_q[27:24]}));
              n        = n + RCNT_W'(1);
              settle_d = SETTLE_W'(1);
              phase_d  = PH_SETTLE_SELECT;
              rl[n]    = stat_rd();
              n        = n + RCNT_W'(1);
            end
          end
          PH_SETTLE_SELECT: begin
            if (settle_q < SETTLE_W'(SETTLE_READS)) begin
              settle_d = settle_q + SETTLE_W'(1);
              rl[n]    = stat_rd();
              n        = n + RCNT_W'(1);
            end else if (op_q == OP_PROBE) begin
              phase_d = PH_PROBE_STATUS;
              rl[n]   = stat_rd();
              n       = n + RCNT_W'(1);
            end else begin
              rl[n]   = byte_wr(REG_COUNT, sect_q);
              n       = n + RCNT_W'(1);
              rl[n]   = byte_wr(REG_LBA0, addr_q[7:0]);
              n       = n + RCNT_W'(1);
              rl[n]   = byte_wr(REG_LBA1, addr_q[15:8]);
              n       = n + RCNT_W'(1);
              rl[n]   = byte_wr(REG_LBA2, addr_q[23:16]);
              n       = n + RCNT_W'(1);
              rl[n]   = byte_wr(REG_STATUS, (op_q == OP_WRITE) ? CMD_WRITE : CMD_READ);
              n       = n + RCNT_W'(1);
              phase_d = PH_BSY_SECTOR;
              poll_d  = 32'd1;
              rl[n]   = stat_rd();
              n       = n + RCNT_W'(1);
            end
          end
          PH_PROBE_STATUS: begin
            rl[n]   = done_res((st != 8'hFF && st != 8'h00) ? DONE_OK : DONE_TIMEOUT);
            n       = n + RCNT_W'(1);
            phase_d = PH_IDLE;
          end
          PH_BSY_SECTOR: begin
            if ((st & ST_BSY) != '0) begin
              do_poll = 1'b1;
            end else begin
              phase_d = PH_DRQ;
              poll_d  = 32'd1;
              rl[n]   = stat_rd();
              n       = n + RCNT_W'(1);
            end
          end
          PH_DRQ: begin
            if ((st & (ST_ERR | ST_DF)) != '0) begin
              rl[n]   = done_res(DONE_ERR);
              n       = n + RCNT_W'(1);
              phase_d = PH_IDLE;
            end else if ((st & ST_DRQ) == '0) begin
              do_poll = 1'b1;
            end else begin
              widx_d = '0;
              if (op_q == OP_WRITE) begin
                phase_d = PH_WRITE_WORD;
                rl[n]   = req_res();
              end else begin
                phase_d = PH_READ_DATA;
                rl[n]   = bus_res(REG_DATA, 1'b0, 1'b1, 16'h0000);
              end
              n = n + RCNT_W'(1);
            end
          end
          PH_READ_DATA: begin
            rl[n] = host_res(item_i.reply);
            n     = n + RCNT_W'(1);
            if (widx_inc != WIDX_W'(SECTOR_WORDS)) begin
              widx_d = widx_inc;
              rl[n]  = bus_res(REG_DATA, 1'b0, 1'b1, 16'h0000);
              n      = n + RCNT_W'(1);
            end else begin
              widx_d = '0;
              sect_d = sect_dec;
              if (sect_dec != '0) begin
                phase_d = PH_BSY_SECTOR;
                poll_d  = 32'd1;
                rl[n]   = stat_rd();
              end else begin
                phase_d = PH_IDLE;
                rl[n]   = done_res(DONE_OK);
              end
              n = n + RCNT_W'(1);
            end
          end
          PH_SETTLE_SECTOR: begin
            if (settle_q < SETTLE_W'(SETTLE_READS)) begin
              settle_d = settle_q + SETTLE_W'(1);
            end else begin
              phase_d = (sect_q != '0) ? PH_BSY_SECTOR : PH_BSY_PREFLUSH;
              poll_d  = 32'd1;
            end
            rl[n] = stat_rd();
            n     = n + RCNT_W'(1);
          end
          PH_BSY_PREFLUSH: begin
            if ((st & ST_BSY) != '0) begin
              do_poll = 1'b1;
            end else begin
              rl[n]   = byte_wr(REG_STATUS, CMD_FLUSH);
              n       = n + RCNT_W'(1);
              phase_d = PH_BSY_POSTFLUSH;
              poll_d  = 32'd1;
              rl[n]   = stat_rd();
              n       = n + RCNT_W'(1);
            end
          end
          PH_BSY_POSTFLUSH: begin
            if ((st & ST_BSY) != '0) begin
              do_poll = 1'b1;
            end else begin
              phase_d = PH_FINAL_STATUS;
              rl[n]   = stat_rd();
              n       = n + RCNT_W'(1);
            end
          end
          PH_FINAL_STATUS: begin
            rl[n]   = done_res(((st & (ST_ERR | ST_DF)) != '0) ? DONE_ERR : DONE_OK);
            n       = n + RCNT_W'(1);
            phase_d = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
      // poll budget check shared by all status waits
      if (do_poll) begin
        if (poll_out) begin
          rl[n]   = done_res(DONE_TIMEOUT);
          phase_d = PH_IDLE;
        end else begin
          poll_d = poll_q + 32'd1;
          rl[n]  = stat_rd();
        end
        n = n + RCNT_W'(1);
      end
      if (n != '0) begin
        rl[n - RCNT_W'(1)].last = 1'b1;
      end
    end
  end

  // result buffer: head drives the output; loads an item's results on pop, else shifts on each transaction
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MAX_RES; i++) begin
      buf_d[i] = buf_q[i];
    end
    if (pop_o) begin
      cnt_d = n;
      for (int i = 0; i < MAX_RES; i++) begin
        buf_d[i] = rl[i];
      end
    end else if (m_hs) begin
      cnt_d = cnt_q - RCNT_W'(1);
      for (int i = 0; i < MAX_RES - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      op_q     <= '0;
      addr_q   <= '0;
      sect_q   <= '0;
      widx_q   <= '0;
      poll_q   <= '0;
      settle_q <= '0;
      spin_q   <= SPIN_RESET;
      cnt_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      op_q     <= op_d;
      addr_q   <= addr_d;
      sect_q   <= sect_d;
      widx_q   <= widx_d;
      poll_q   <= poll_d;
      settle_q <= settle_d;
      cnt_q    <= cnt_d;
      if (cfg_we_i) begin
        spin_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RES; i++) begin
      buf_q[i] <= buf_d[i];
    end
  end

endmodule

// ===== rtl/ata_pio_lba28_command_engine.sv =====
`timescale 1ns / 1ps
// ATA PIO LBA28 host sequencer for the master drive.
// s_axis carries commands (read, write, probe), bus read replies and host
// write words; tuser holds the action code. m_axis carries the results: task
// file bus accesses, data words for the host, write word requests and the
// done report; tuser holds the result kind, tlast marks the final result of
// the input transaction that caused it. Every bus read on m_axis must be
// answered later by a reply transaction on s_axis.
// cfg carries the spin limit (status polls allowed per wait); cfg_ready_o is
// always high, write it only while the block is idle.
// Inputs pass a decode register and a two-entry command queue; results are
// registered in the result buffer that drives m_axis. The sequencer takes
// one item per cycle while the buffer is empty or sends its last result, and
// emits up to six results, one per cycle while m_axis is ready: a one-result
// item sustains one transaction per cycle, a longer one holds back the next
// item until the buffer drains. If m_axis stalls, results wait in the buffer,
// the queue fills and s_axis_tready drops. Reset clears the queue, the buffer
// and the sequencer (idle, spin limit 4000000); no clearing pass is needed.
module ata_pio_lba28_command_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [31:0]                   cfg_data_i,
  // command and reply stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // lba[27:0], sector_count[35:28], reply_data[51:36], write_word[67:52], zero pad
  input  logic [ata_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // action[2:0]
  input  logic [ata_pkg::S_TUSER_W-1:0] s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // port_offset[2:0], bus_write[3], word_access[4], bus_data[20:5],
  // host_data[36:21], done_status[38:37], zero pad
  output logic [ata_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // kind[1:0]
  output logic [ata_pkg::M_TUSER_W-1:0] m_axis_tuser,
  output logic                          m_axis_tlast
);
  import ata_pkg::*;

  item_t front_item;
  item_t queue_item;
  logic  front_push;
  logic  queue_full;
  logic  queue_valid;
  logic  queue_pop;
  res_t  res;
  logic  cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  // front: accept and classify each input transaction
  ata_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .push_o    (front_push),
    .item_o    (front_item),
    .full_i    (queue_full)
  );

  // short command queue decoupling front and sequencer
  ata_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .item_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .valid_o (queue_valid),
    .item_o  (queue_item)
  );

  // back: sequencer and result buffer
  ata_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data_i),
    .valid_i    (queue_valid),
    .item_i     (queue_item),
    .pop_o      (queue_pop),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .res_o      (res)
  );

  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;
  assign m_axis_tdata = {1'b0, res.done_status, res.host_data, res.bus_data,
                         res.word_access, res.bus_write, res.port};

endmodule

// ===== rtl/ata_checker.sv =====
`timescale 1ns / 1ps
module ata_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ata_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [ata_pkg::M_TUSER_W-1:0] m_axis_tuser,
  input logic                          m_axis_tlast
);
  import ata_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // done report always ends the results of its input
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_DONE |-> m_axis_tlast)
    else $error("done not last");

  // a host data word is always followed by another result of the same input
  a_host_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_HOST |-> !m_axis_tlast)
    else $error("host word marked last");

  // write word request is always the final result
  a_req_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_REQ |-> m_axis_tlast)
    else $error("request not last");

  // completion code stays in range
  a_done_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == KIND_DONE |->
      m_axis_tdata[MD_ST_LSB+1:MD_ST_LSB] != 2'd3)
    else $error("bad completion code");

endmodule

bind ata_pio_lba28_command_engine ata_checker u_ata_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import ata_pkg::*;

  // clocking, watchdog and pacing
  localparam int unsigned QUIET_LIMIT = 2000;  // cycles without any transaction
  localparam int unsigned TAIL_CYCLES = 12;    // pipeline depth plus margin
  localparam int unsigned PHASE_ITEMS = 14;    // counted items per spin limit setting

  // spin limit settings walked by the random part, the extremes among them
  localparam int unsigned N_PHASES = 5;
  localparam logic [31:0] SPIN_PLAN [N_PHASES] = '{
    32'd3, 32'd1, 32'd0, 32'd2, 32'hFFFF_FFFF
  };

  // action codes the block does not know
  localparam logic [2:0] ACT_FIRST_UNUSED = ACT_WWORD + 3'd1;
  localparam logic [2:0] ACT_LAST_UNUSED  = '1;

  // probe status values meaning no drive
  localparam logic [7:0] PROBE_FLOAT = 8'hFF;
  localparam logic [7:0] PROBE_EMPTY = 8'h00;

  localparam logic [27:0] LBA_MAX   = '1;
  localparam logic [7:0]  COUNT_MAX = '1;

  // single results known at a glance: {kind, port, wr, word, bus, host, status, last}
  localparam res_t WANT_POLL = {KIND_BUS, REG_STATUS, 1'b0, 1'b0, 16'h0, 16'h0, DONE_OK, 1'b1};
  localparam res_t WANT_OK   = {KIND_DONE, 3'b000, 1'b0, 1'b0, 16'h0, 16'h0, DONE_OK, 1'b1};
  localparam res_t WANT_ERR  = {KIND_DONE, 3'b000, 1'b0, 1'b0, 16'h0, 16'h0, DONE_ERR, 1'b1};
  localparam res_t WANT_TMO  = {KIND_DONE, 3'b000, 1'b0, 1'b0, 16'h0, 16'h0, DONE_TIMEOUT, 1'b1};

  // sequencer phases as seen by the predictor
  typedef enum logic [3:0] {
    SQ_IDLE, SQ_BSY_ISSUE, SQ_SETTLE_SEL, SQ_PROBE_ST, SQ_BSY_SECTOR, SQ_DRQ,
    SQ_READ_DATA, SQ_WRITE_WORD, SQ_SETTLE_SECTOR, SQ_BSY_PREFLUSH,
    SQ_BSY_POSTFLUSH, SQ_FINAL_ST
  } sq_phase_e;

  // how a directed row is checked
  typedef enum logic [1:0] {CHK_MODEL, CHK_ONE, CHK_NONE} row_chk_e;

  typedef struct packed {
    logic [2:0]  act;
    logic [27:0] lba;
    logic [7:0]  count;
    logic [15:0] reply;
    logic [15:0] wword;
  } host_item_t;

  typedef struct {
    host_item_t it;
    row_chk_e   chk;
    res_t       want;
  } dir_row_t;

  // dut ports
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [31:0]          cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic [S_TUSER_W-1:0] s_axis_tuser;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic [M_TUSER_W-1:0] m_axis_tuser;
  logic                 m_axis_tlast;

  // predictor copy of the sequencer
  sq_phase_e   seq_ph;
  logic [1:0]  seq_op;
  logic [27:0] seq_lba;
  logic [7:0]  seq_left;
  int unsigned seq_widx;
  logic [31:0] seq_polls;
  int unsigned seq_settle;
  logic [31:0] spin_lim;

  res_t     burst[$];        // results of the item being predicted
  res_t     expected_res[$]; // results still owed by the dut
  dir_row_t dir_rows[$];

  int  mismatches = 0;
  int  quiet      = 0;
  int  stall_left = 0;
  int  wr_sectors = 0;       // sectors fully written so far
  int  burst_n;
  bit  bursts_on;            // random idling on both sides
  bit  abort_run;            // current command is to fail on device error
  bit  data_wanted;          // a one sector write may move its data now

  ata_pio_lba28_command_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic void emit(logic [1:0] kind, logic [2:0] port, logic wr, logic word,
                               logic [15:0] bd, logic [15:0] hd, logic [1:0] st);
    res_t r;
    r             = '0;
    r.kind        = kind;
    r.port        = port;
    r.bus_write   = wr;
    r.word_access = word;
    r.bus_data    = bd;
    r.host_data   = hd;
    r.done_status = st;
    burst.push_back(r);
  endfunction

  function automatic void poll_status();
    emit(KIND_BUS, REG_STATUS, 1'b0, 1'b0, '0, '0, '0);
  endfunction

  function automatic void reg_write(logic [2:0] port, logic [7:0] v);
    emit(KIND_BUS, port, 1'b1, 1'b0, {8'h00, v}, '0, '0);
  endfunction

  function automatic void end_cmd(logic [1:0] st);
    emit(KIND_DONE, '0, 1'b0, 1'b0, '0, '0, st);
    seq_ph = SQ_IDLE;
  endfunction

  // first status read of a wait, budget restarts
  function automatic void begin_wait(sq_phase_e next);
    seq_ph    = next;
    seq_polls = 1;
    poll_status();
  endfunction

  // another poll, or a timeout once the budget is spent (zero counts as one)
  function automatic void poll_again();
    logic [31:0] lim;
    lim = (spin_lim == 0) ? 32'd1 : spin_lim;
    if (seq_polls >= lim) begin
      end_cmd(DONE_TIMEOUT);
    end else begin
      seq_polls++;
      poll_status();
    end
  endfunction

  // a bus read reply, only the low byte counts as status
  function automatic void answer_read(logic [15:0] rep);
    logic [7:0] st;
    st = rep[7:0];
    case (seq_ph)
      SQ_BSY_ISSUE: begin
        if ((st & ST_BSY) != 0) begin
          poll_again();
        end else begin
          reg_write(REG_DEVICE, (seq_op == OP_PROBE) ? DEV_SEL
                                                     : (DEV_SEL | {4'h0, seq_lba[27:24]}));
          seq_settle = 1;
          seq_ph     = SQ_SETTLE_SEL;
          poll_status();
        end
      end
      SQ_SETTLE_SEL: begin
        if (seq_settle < SETTLE_READS) begin
          seq_settle++;
          poll_status();
        end else if (seq_op == OP_PROBE) begin
          seq_ph = SQ_PROBE_ST;
          poll_status();
        end else begin
          // program the task file and issue the command
          reg_write(REG_COUNT, seq_left);
          reg_write(REG_LBA0, seq_lba[7:0]);
          reg_write(REG_LBA1, seq_lba[15:8]);
          reg_write(REG_LBA2, seq_lba[23:16]);
          reg_write(REG_STATUS, (seq_op == OP_WRITE) ? CMD_WRITE : CMD_READ);
          begin_wait(SQ_BSY_SECTOR);
        end
      end
      SQ_PROBE_ST: begin
        end_cmd((st != PROBE_FLOAT && st != PROBE_EMPTY) ? DONE_OK : DONE_TIMEOUT);
      end
      SQ_BSY_SECTOR: begin
        if ((st & ST_BSY) != 0) poll_again();
        else begin_wait(SQ_DRQ);
      end
      SQ_DRQ: begin
        if ((st & (ST_ERR | ST_DF)) != 0) begin
          end_cmd(DONE_ERR);
        end else if ((st & ST_DRQ) == 0) begin
          poll_again();
        end else begin
          seq_widx = 0;
          if (seq_op == OP_WRITE) begin
            seq_ph = SQ_WRITE_WORD;
            emit(KIND_REQ, '0, 1'b0, 1'b0, '0, '0, '0);
          end else begin
            seq_ph = SQ_READ_DATA;
            emit(KIND_BUS, REG_DATA, 1'b0, 1'b1, '0, '0, '0);
          end
        end
      end
      SQ_READ_DATA: begin
        emit(KIND_HOST, '0, 1'b0, 1'b0, '0, rep, '0);
        seq_widx++;
        if (seq_widx < SECTOR_WORDS) begin
          emit(KIND_BUS, REG_DATA, 1'b0, 1'b1, '0, '0, '0);
        end else begin
          seq_widx = 0;
          seq_left = seq_left - 8'd1;
          if (seq_left != 0) begin_wait(SQ_BSY_SECTOR);
          else end_cmd(DONE_OK);
        end
      end
      SQ_SETTLE_SECTOR: begin
        if (seq_settle < SETTLE_READS) begin
          seq_settle++;
          poll_status();
        end else begin
          begin_wait((seq_left != 0) ? SQ_BSY_SECTOR : SQ_BSY_PREFLUSH);
        end
      end
      SQ_BSY_PREFLUSH: begin
        if ((st & ST_BSY) != 0) begin
          poll_again();
        end else begin
          reg_write(REG_STATUS, CMD_FLUSH);
          begin_wait(SQ_BSY_POSTFLUSH);
        end
      end
      SQ_BSY_POSTFLUSH: begin
        if ((st & ST_BSY) != 0) begin
          poll_again();
        end else begin
          seq_ph = SQ_FINAL_ST;
          poll_status();
        end
      end
      SQ_FINAL_ST: begin
        end_cmd(((st & (ST_ERR | ST_DF)) != 0) ? DONE_ERR : DONE_OK);
      end
      default: ;
    endcase
  endfunction

  // results caused by one accepted item land in burst, last one flagged
  function automatic void predict_item(host_item_t it);
    burst.delete();
    if (seq_ph == SQ_IDLE) begin
      if (it.act == ACT_READ || it.act == ACT_WRITE) begin
        if (it.count == 0) begin
          end_cmd(DONE_OK);
        end else begin
          seq_op   = (it.act == ACT_WRITE) ? OP_WRITE : OP_READ;
          seq_lba  = it.lba;
          seq_left = it.count;
          begin_wait(SQ_BSY_ISSUE);
        end
      end else if (it.act == ACT_PROBE) begin
        seq_op = OP_PROBE;
        begin_wait(SQ_BSY_ISSUE);
      end
    end else if (seq_ph == SQ_WRITE_WORD) begin
      if (it.act == ACT_WWORD) begin
        emit(KIND_BUS, REG_DATA, 1'b1, 1'b1, it.wword, '0, '0);
        seq_widx++;
        if (seq_widx < SECTOR_WORDS) begin
          emit(KIND_REQ, '0, 1'b0, 1'b0, '0, '0, '0);
        end else begin
          seq_widx   = 0;
          seq_left   = seq_left - 8'd1;
          seq_settle = 1;
          seq_ph     = SQ_SETTLE_SECTOR;
          wr_sectors++;
          poll_status();
        end
      end
    end else if (it.act == ACT_REPLY) begin
      answer_read(it.reply);
    end
    if (burst.size() != 0) burst[burst.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic void add_row(logic [2:0] act, logic [27:0] lba, logic [7:0] cnt,
                                  logic [15:0] data, row_chk_e chk, res_t want);
    dir_row_t row;
    row.it    = '{act: act, lba: lba, count: cnt, reply: data, wword: data};
    row.chk   = chk;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // next item chosen from where the sequencer stands: mostly well formed
  // traffic with random content, a little noise the block must ignore
  function automatic host_item_t pick_item();
    host_item_t it;
    int unsigned roll;
    it.act   = ACT_REPLY;
    it.lba   = 28'($urandom);
    it.count = 8'($urandom);
    it.reply = 16'($urandom);
    it.wword = 16'($urandom);
    roll     = $urandom_range(0, 99);
    if (seq_ph != SQ_IDLE && roll < 5) begin
      it.act = 3'($urandom_range(0, 7));
      if (seq_ph == SQ_WRITE_WORD) begin
        if (it.act == ACT_WWORD) it.act = ACT_REPLY;
      end else if (it.act == ACT_REPLY) begin
        it.act = ACT_WWORD;
      end
      return it;
    end
    case (seq_ph)
      SQ_IDLE: begin
        if (roll < 8) begin
          it.act = 3'(ACT_REPLY + $urandom_range(0, 4));
        end else if (roll < 16) begin
          it.act   = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
          it.count = '0;
        end else if (roll < 36) begin
          it.act = ACT_PROBE;
        end else begin
          // data moves only for a one sector write when one is wanted,
          // every other run is cut short by a device error, if no wait times out first
          it.act = $urandom_range(0, 1) ? ACT_WRITE : ACT_READ;
          roll   = $urandom_range(0, 9);
          if (roll < 6) it.count = 8'd1;
          else if (roll < 7) it.count = 8'd2;
          abort_run = !(data_wanted && it.act == ACT_WRITE && it.count == 8'd1);
        end
      end
      SQ_WRITE_WORD: it.act = ACT_WWORD;
      SQ_BSY_ISSUE, SQ_BSY_SECTOR, SQ_BSY_PREFLUSH, SQ_BSY_POSTFLUSH: begin
        it.reply[7] = ($urandom_range(0, 3) == 0);
      end
      SQ_DRQ: begin
        if (abort_run) begin
          it.reply[0] = 1'($urandom);
          it.reply[5] = !it.reply[0] || 1'($urandom);
        end else begin
          it.reply[0] = 1'b0;
          it.reply[5] = 1'b0;
          it.reply[3] = ($urandom_range(0, 4) != 0);
        end
      end
      SQ_PROBE_ST: begin
        roll = $urandom_range(0, 4);
        if (roll == 0) it.reply[7:0] = PROBE_FLOAT;
        else if (roll == 1) it.reply[7:0] = PROBE_EMPTY;
      end
      SQ_FINAL_ST: begin
        if ($urandom_range(0, 3) != 0) begin
          it.reply[0] = 1'b0;
          it.reply[5] = 1'b0;
        end
      end
      default: ;
    endcase
    return it;
  endfunction

  // one s_axis transaction; prediction happens at the accepting edge
  task automatic send_item(host_item_t it, row_chk_e chk, res_t want);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    s_axis_tuser  = it.act;
    s_axis_tdata  = S_TDATA_W'({it.wword, it.reply, it.count, it.lba});
    s_axis_tvalid = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_item(it);
    burst_n = burst.size();
    case (chk)
      CHK_MODEL: foreach (burst[i]) expected_res.push_back(burst[i]);
      CHK_ONE:   expected_res.push_back(want);
      default:   ;
    endcase
    @(negedge clk_i);
  endtask

  // stop driving and wait until every owed result has come out
  task automatic drain_results();
    s_axis_tvalid = 1'b0;
    while (expected_res.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // checking
  // ---------------------------------------------------------------------------

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // every m_axis transaction against the oldest expectation
  always @(posedge clk_i) begin : watch_results
    res_t got;
    res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind        = m_axis_tuser;
      got.port        = m_axis_tdata[MD_PORT_LSB +: 3];
      got.bus_write   = m_axis_tdata[MD_WR_BIT];
      got.word_access = m_axis_tdata[MD_WORD_BIT];
      got.bus_data    = m_axis_tdata[MD_BD_LSB +: 16];
      got.host_data   = m_axis_tdata[MD_HD_LSB +: 16];
      got.done_status = m_axis_tdata[MD_ST_LSB +: 2];
      got.last        = m_axis_tlast;
      if (expected_res.size() == 0) begin
        flag_mismatch("result with nothing pending", 32'(got.kind), '0);
      end else begin
        want = expected_res.pop_front();
        if (got.kind != want.kind)
          flag_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.port != want.port)
          flag_mismatch("port_offset", 32'(got.port), 32'(want.port));
        if (got.bus_write != want.bus_write)
          flag_mismatch("bus_write", 32'(got.bus_write), 32'(want.bus_write));
        if (got.word_access != want.word_access)
          flag_mismatch("word_access", 32'(got.word_access), 32'(want.word_access));
        if (got.bus_data != want.bus_data)
          flag_mismatch("bus_data", 32'(got.bus_data), 32'(want.bus_data));
        if (got.host_data != want.host_data)
          flag_mismatch("host_data", 32'(got.host_data), 32'(want.host_data));
        if (got.done_status != want.done_status)
          flag_mismatch("done_status", 32'(got.done_status), 32'(want.done_status));
        if (got.last != want.last)
          flag_mismatch("tlast", 32'(got.last), 32'(want.last));
      end
    end
  end

  // result side back-pressure in random bursts
  always @(negedge clk_i) begin
    if (stall_left != 0) stall_left--;
    else if (bursts_on && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 5);
    m_axis_tready = (stall_left == 0);
  end

  // no transaction on any channel for too long ends the run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QUIET_LIMIT) begin
          $display("watchdog: no transaction for %0d cycles, %0d results pending",
                   quiet, expected_res.size());
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int taken;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    bursts_on     = 1'b1;
    abort_run     = 1'b0;
    data_wanted   = 1'b0;

    // predictor comes out of reset with the block
    seq_ph     = SQ_IDLE;
    seq_op     = OP_READ;
    seq_lba    = '0;
    seq_left   = '0;
    seq_widx   = 0;
    seq_polls  = '0;
    seq_settle = 0;
    spin_lim   = SPIN_RESET;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed part, at the reset spin limit
    // ignored items in idle, unknown actions
    add_row(ACT_REPLY, '0, '0, 16'hFFFF, CHK_NONE, '0);
    add_row(ACT_WWORD, '0, '0, 16'hFFFF, CHK_NONE, '0);
    add_row(ACT_FIRST_UNUSED, '0, '0, 16'h0000, CHK_NONE, '0);
    add_row(ACT_LAST_UNUSED, LBA_MAX, COUNT_MAX, 16'hFFFF, CHK_NONE, '0);
    // zero sector count completes at once
    add_row(ACT_READ, LBA_MAX, '0, 16'h0000, CHK_ONE, WANT_OK);
    add_row(ACT_WRITE, '0, '0, 16'h0000, CHK_ONE, WANT_OK);
    // probe, starts while busy are dropped
    add_row(ACT_PROBE, '0, '0, 16'h0000, CHK_ONE, WANT_POLL);
    add_row(ACT_PROBE, '0, '0, 16'h0000, CHK_NONE, '0);
    add_row(ACT_READ, '0, 8'd1, 16'h0000, CHK_NONE, '0);
    // bsy set keeps polling, high byte of the reply is not status
    add_row(ACT_REPLY, '0, '0, 16'h0080, CHK_ONE, WANT_POLL);
    add_row(ACT_REPLY, '0, '0, 16'hFF7F, CHK_MODEL, '0);
    add_row(ACT_REPLY, '0, '0, 16'h0000, CHK_ONE, WANT_POLL);
    add_row(ACT_REPLY, '0, '0, 16'hFFFF, CHK_ONE, WANT_POLL);
    add_row(ACT_REPLY, '0, '0, 16'h0000, CHK_ONE, WANT_POLL);
    add_row(ACT_REPLY, '0, '0, 16'h1234, CHK_MODEL, '0);
    // status byte zero means no drive
    add_row(ACT_REPLY, '0, '0, 16'h5500, CHK_ONE, WANT_TMO);
    // read at the top lba with the largest count, ends on ERR and DF
    add_row(ACT_READ, LBA_MAX, COUNT_MAX, 16'h0000, CHK_ONE, WANT_POLL);
    add_row(ACT_REPLY, '0, '0, 16'h0000, CHK_MODEL, '0);
    add_row(ACT_REPLY, '0, '0, 16'hFFFF, CHK_MODEL, '0);
    add_row(ACT_REPLY, '0, '0, 16'h0000, CHK_MODEL, '0);
    add_row(ACT_REPLY, '0, '0, 16'hFFFF, CHK_MODEL, '0);
    add_row(ACT_WWORD, '0, '0, 16'hFFFF, CHK_NONE, '0);
    add_row(ACT_REPLY, '0, '0, 16'h0000, CHK_MODEL, '0);
    add_row(ACT_REPLY, '0, '0, 16'h0000, CHK_MODEL, '0);
    add_row(ACT_REPLY, '0, '0, 16'h0021, CHK_ONE, WANT_ERR);
    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].chk, dir_rows[i].want);

    // random part, one spin limit per phase, written while idle
    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      cfg_data_i  = SPIN_PLAN[p];
      cfg_valid_i = 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      spin_lim = SPIN_PLAN[p];
      @(negedge clk_i);
      cfg_valid_i = 1'b0;
      bursts_on   = (p != N_PHASES - 1);
      taken       = 0;
      // ignored items do not count; the last phase also sees a full
      // write sector through, with flush and final status
      while (taken < PHASE_ITEMS || seq_ph != SQ_IDLE ||
             (p == N_PHASES - 1 && wr_sectors == 0)) begin
        data_wanted = (p == N_PHASES - 1) && (wr_sectors == 0);
        send_item(pick_item(), CHK_MODEL, '0);
        if (burst_n != 0) taken++;
      end
    end

    drain_results();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
